// ===== hdl/dltq_pkg.sv =====
package dltq_pkg;

  localparam int MAX_RESULTS = 16;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_CANCELLED = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_EXPIRED   = 3'd5;
  localparam logic [2:0] ST_IDLE      = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_WT,
    S_DEC,
    S_IN_RD,
    S_IN_WT,
    S_IN_PUT,
    S_CA_RD,
    S_CA_WT,
    S_TK_RD,
    S_TK_WT,
    S_TK_DEC,
    S_EX_RD,
    S_EX_WT,
    S_CM_RD,
    S_CM_WT
  } state_t;

  typedef enum logic {
    S_EMIT_OFF,
    S_EMIT_ON
  } emit_t;

endpackage

// ===== hdl/delta_list_timer_queue.sv =====
// channel  dir  tdata (low bit up)                              tuser    tlast
// s_axis   in   timer_key, amount_us                             op       -
// m_axis   out  result_key, next_timeout_us, queue_empty         status   last
//
// One item at a time. A request walks the stored entries for the key search,
// decides, shifts entries on insert or cancel, places an insert and loads
// the result. A tick walks the entries, decides, emits each expired entry
// and moves the entries behind them down; with nothing expiring it loads the
// result, and on an empty list it only loads the result.
// rst clears the FSM, entry count and output valid; the RAM holds no reset.
// Results wait in the output register; the walk stalls while it is full.
module delta_list_timer_queue #(
  parameter int DEPTH = 16,
  parameter int KEY_BITS = 16,
  parameter int TIME_BITS = 32,
  localparam int IN_W = ((KEY_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((KEY_BITS + TIME_BITS + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // timer_key, amount_us
  input  logic             s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // result_key, next_timeout_us, queue_empty
  output logic [2:0]       m_axis_tuser,  // status
  output logic             m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_BITS + TIME_BITS;
  localparam int NMAX = (DEPTH < dltq_pkg::MAX_RESULTS) ? DEPTH : dltq_pkg::MAX_RESULTS;

  dltq_pkg::state_t state, state_next;
  dltq_pkg::emit_t  emit, emit_next;

  logic [CW-1:0]        ptr, cnt, ipos, fpos, z, nexp;
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_BITS-1:0] amt_r, head, fdelta;
  logic                 nz, found, iset;
  logic [2:0]           st_r;

  logic [KEY_BITS-1:0]  o_key;
  logic [TIME_BITS-1:0] o_head;
  logic                 o_empty, o_last;
  logic [2:0]           o_st;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic [EW-1:0]        rdata;
  logic [KEY_BITS-1:0]  rkey;
  logic [TIME_BITS-1:0] rdel;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] sat;
  logic [CW-1:0]        nsel, ptr_inc, wtmp;
  logic                 out_free, at_end, out_load;

  dltq_ram #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ptr[AW-1:0]),
    .rdata(rdata)
  );

  assign rkey     = rdata[EW-1:TIME_BITS];
  assign rdel     = rdata[TIME_BITS-1:0];
  assign sum      = {1'b0, rdel} + {1'b0, fdelta};
  assign sat      = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign nsel     = (z > CW'(NMAX)) ? CW'(NMAX) : z;
  assign ptr_inc  = ptr + CW'(1);
  assign at_end   = (ptr_inc == cnt);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = out_free && (((state == dltq_pkg::S_IDLE) &&
                                  (emit == dltq_pkg::S_EMIT_ON)) ||
                                 (state == dltq_pkg::S_EX_WT));

  assign m_axis_tdata = OUT_W'({o_empty, o_head, o_key});
  assign m_axis_tuser = o_st;
  assign m_axis_tlast = o_last;

  // next state
  always_comb begin
    state_next = state;
    emit_next  = emit;
    case (state)
      dltq_pkg::S_IDLE: begin
        if (emit == dltq_pkg::S_EMIT_ON) begin
          if (out_free) emit_next = dltq_pkg::S_EMIT_OFF;
        end else if (s_axis_tvalid) begin
          if (!s_axis_tuser) begin
            state_next = (cnt == '0) ? dltq_pkg::S_DEC : dltq_pkg::S_SC_RD;
          end else if (cnt == '0) begin
            emit_next = dltq_pkg::S_EMIT_ON;
          end else begin
            state_next = dltq_pkg::S_TK_RD;
          end
        end
      end
      dltq_pkg::S_SC_RD: state_next = dltq_pkg::S_SC_WT;
      dltq_pkg::S_SC_WT: state_next = at_end ? dltq_pkg::S_DEC : dltq_pkg::S_SC_RD;
      dltq_pkg::S_DEC: begin
        if (nz) begin
          if (found || cnt == CW'(DEPTH)) begin
            state_next = dltq_pkg::S_IDLE;
            emit_next  = dltq_pkg::S_EMIT_ON;
          end else if (ipos < cnt) begin
            state_next = dltq_pkg::S_IN_RD;
          end else begin
            state_next = dltq_pkg::S_IN_PUT;
          end
        end else if (found && (fpos + CW'(1) < cnt)) begin
          state_next = dltq_pkg::S_CA_RD;
        end else begin
          state_next = dltq_pkg::S_IDLE;
          emit_next  = dltq_pkg::S_EMIT_ON;
        end
      end
      dltq_pkg::S_IN_RD: state_next = dltq_pkg::S_IN_WT;
      dltq_pkg::S_IN_WT: state_next = (ptr == ipos) ? dltq_pkg::S_IN_PUT : dltq_pkg::S_IN_RD;
      dltq_pkg::S_IN_PUT: begin
        state_next = dltq_pkg::S_IDLE;
        emit_next  = dltq_pkg::S_EMIT_ON;
      end
      dltq_pkg::S_CA_RD: state_next = dltq_pkg::S_CA_WT;
      dltq_pkg::S_CA_WT: begin
        if (at_end) begin
          state_next = dltq_pkg::S_IDLE;
          emit_next  = dltq_pkg::S_EMIT_ON;
        end else begin
          state_next = dltq_pkg::S_CA_RD;
        end
      end
      dltq_pkg::S_TK_RD: state_next = dltq_pkg::S_TK_WT;
      dltq_pkg::S_TK_WT: begin
        if (rdel > amt_r || at_end) state_next = dltq_pkg::S_TK_DEC;
        else state_next = dltq_pkg::S_TK_RD;
      end
      dltq_pkg::S_TK_DEC: begin
        if (z == '0) begin
          state_next = dltq_pkg::S_IDLE;
          emit_next  = dltq_pkg::S_EMIT_ON;
        end else begin
          state_next = dltq_pkg::S_EX_RD;
        end
      end
      dltq_pkg::S_EX_RD: state_next = dltq_pkg::S_EX_WT;
      dltq_pkg::S_EX_WT: begin
        if (out_free) begin
          if (ptr_inc == nexp) begin
            state_next = (cnt == '0) ? dltq_pkg::S_IDLE : dltq_pkg::S_CM_RD;
          end else begin
            state_next = dltq_pkg::S_EX_RD;
          end
        end
      end
      dltq_pkg::S_CM_RD: state_next = dltq_pkg::S_CM_WT;
      dltq_pkg::S_CM_WT: begin
        state_next = (ptr_inc == cnt + nexp) ? dltq_pkg::S_IDLE : dltq_pkg::S_CM_RD;
      end
      default: state_next = dltq_pkg::S_IDLE;
    endcase
  end

  // RAM write port and input handshake
  always_comb begin
    we    = 1'b0;
    wtmp  = '0;
    wdata = '0;
    s_axis_tready = (state == dltq_pkg::S_IDLE) && (emit == dltq_pkg::S_EMIT_OFF);
    case (state)
      dltq_pkg::S_IN_WT: begin
        we    = 1'b1;
        wtmp  = ptr_inc;
        wdata = {rkey, (ptr == ipos) ? rdel - amt_r : rdel};
      end
      dltq_pkg::S_IN_PUT: begin
        we    = 1'b1;
        wtmp  = ipos;
        wdata = {key_r, amt_r};
      end
      dltq_pkg::S_CA_WT: begin
        we    = 1'b1;
        wtmp  = ptr - CW'(1);
        wdata = {rkey, (ptr == fpos + CW'(1)) ? sat : rdel};
      end
      dltq_pkg::S_TK_WT: begin
        we    = 1'b1;
        wtmp  = ptr;
        wdata = {rkey, (rdel > amt_r) ? rdel - amt_r : {TIME_BITS{1'b0}}};
      end
      dltq_pkg::S_CM_WT: begin
        we    = 1'b1;
        wtmp  = ptr - nexp;
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
    waddr = wtmp[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dltq_pkg::S_IDLE;
      emit          <= dltq_pkg::S_EMIT_OFF;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      emit  <= emit_next;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        dltq_pkg::S_IDLE: begin
          if (emit == dltq_pkg::S_EMIT_ON) begin
            if (out_free) begin
              o_st    <= st_r;
              o_key   <= key_r;
              o_head  <= (cnt == '0) ? '0 : head;
              o_empty <= (cnt == '0);
              o_last  <= 1'b1;
            end
          end else if (s_axis_tvalid) begin
            key_r <= s_axis_tuser ? '0 : s_axis_tdata[KEY_BITS-1:0];
            amt_r <= s_axis_tdata[EW-1:KEY_BITS];
            nz    <= (s_axis_tdata[EW-1:KEY_BITS] != '0);
            ptr   <= '0;
            found <= 1'b0;
            iset  <= 1'b0;
            ipos  <= cnt;
            z     <= '0;
            if (s_axis_tuser) st_r <= dltq_pkg::ST_IDLE;
          end
        end
        dltq_pkg::S_SC_WT: begin
          if (ptr == '0) head <= rdel;
          if (!found && rkey == key_r) begin
            found  <= 1'b1;
            fpos   <= ptr;
            fdelta <= rdel;
          end
          if (!iset) begin
            if (amt_r >= rdel) begin
              amt_r <= amt_r - rdel;
            end else begin
              iset <= 1'b1;
              ipos <= ptr;
            end
          end
          ptr <= ptr_inc;
        end
        dltq_pkg::S_DEC: begin
          if (nz) begin
            ptr <= cnt - CW'(1);
            if (found) st_r <= dltq_pkg::ST_DUPLICATE;
            else if (cnt == CW'(DEPTH)) st_r <= dltq_pkg::ST_FULL;
            else st_r <= dltq_pkg::ST_INSERTED;
          end else if (!found) begin
            st_r <= dltq_pkg::ST_NOT_FOUND;
          end else begin
            st_r <= dltq_pkg::ST_CANCELLED;
            if (fpos + CW'(1) < cnt) ptr <= fpos + CW'(1);
            else cnt <= cnt - CW'(1);
          end
        end
        dltq_pkg::S_IN_WT: begin
          if (ptr != ipos) ptr <= ptr - CW'(1);
        end
        dltq_pkg::S_IN_PUT: begin
          cnt <= cnt + CW'(1);
          if (ipos == '0) head <= amt_r;
        end
        dltq_pkg::S_CA_WT: begin
          if (ptr == CW'(1)) head <= (fpos == '0) ? sat : rdel;
          if (at_end) cnt <= cnt - CW'(1);
          else ptr <= ptr_inc;
        end
        dltq_pkg::S_TK_WT: begin
          if (rdel > amt_r) begin
            head <= rdel - amt_r;
          end else begin
            amt_r <= amt_r - rdel;
            z     <= z + CW'(1);
            ptr   <= ptr_inc;
          end
        end
        dltq_pkg::S_TK_DEC: begin
          nexp <= nsel;
          cnt  <= cnt - nsel;
          ptr  <= '0;
          if (nsel < z) head <= '0;
        end
        dltq_pkg::S_EX_WT: begin
          if (out_free) begin
            o_st    <= dltq_pkg::ST_EXPIRED;
            o_key   <= rkey;
            o_head  <= (cnt == '0) ? '0 : head;
            o_empty <= (cnt == '0);
            o_last  <= (ptr_inc == nexp);
            ptr     <= ptr_inc;
          end
        end
        dltq_pkg::S_CM_WT: begin
          ptr <= ptr_inc;
        end
        default: ptr <= ptr;
      endcase
    end
  end

endmodule

// ===== hdl/dltq_ram.sv =====
module dltq_ram #(
  parameter int DEPTH = 16,
  parameter int AW = 4,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/delta_list_timer_queue_test.sv =====
module delta_list_timer_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] key;
    logic [31:0] head;
    logic        empty;
    logic        last;
  } timer_result_t;

  class timer_scoreboard;
    logic [15:0] keys[DEPTH];
    logic [31:0] deltas[DEPTH];
    int count;
    timer_result_t pending[$];
    int errors;

    function void clear();
      count = 0;
      errors = 0;
      pending.delete();
    endfunction

    function int find(logic [15:0] k);
      for (int i = 0; i < count; i++) if (keys[i] == k) return i;
      return -1;
    endfunction

    function void drop_at(int p);
      for (int i = p; i + 1 < count; i++) begin
        keys[i] = keys[i+1];
        deltas[i] = deltas[i+1];
      end
      count--;
    endfunction

    function void note_item(logic op, logic [15:0] k, logic [31:0] amt);
      logic [2:0] st[$];
      logic [15:0] ks[$];
      int p;
      int n;
      logic [32:0] sum;
      if (!op) begin
        p = find(k);
        if (amt != 0) begin
          if (p >= 0) st.push_back(dltq_pkg::ST_DUPLICATE);
          else if (count >= DEPTH) st.push_back(dltq_pkg::ST_FULL);
          else begin
            p = 0;
            while (p < count && amt >= deltas[p]) begin
              amt -= deltas[p];
              p++;
            end
            for (int i = count; i > p; i--) begin
              keys[i] = keys[i-1];
              deltas[i] = deltas[i-1];
            end
            keys[p] = k;
            deltas[p] = amt;
            count++;
            if (p + 1 < count) deltas[p+1] -= amt;
            st.push_back(dltq_pkg::ST_INSERTED);
          end
        end else if (p < 0) st.push_back(dltq_pkg::ST_NOT_FOUND);
        else begin
          if (p + 1 < count) begin
            sum = deltas[p+1] + deltas[p];
            deltas[p+1] = sum[32] ? 32'hffff_ffff : sum[31:0];
          end
          drop_at(p);
          st.push_back(dltq_pkg::ST_CANCELLED);
        end
        ks.push_back(k);
      end else begin
        for (int i = 0; i < count; i++) begin
          if (deltas[i] > amt) begin
            deltas[i] -= amt;
            break;
          end
          amt -= deltas[i];
          deltas[i] = 0;
        end
        while (count > 0 && deltas[0] == 0 && st.size() < dltq_pkg::MAX_RESULTS) begin
          st.push_back(dltq_pkg::ST_EXPIRED);
          ks.push_back(keys[0]);
          drop_at(0);
        end
        if (st.size() == 0) begin
          st.push_back(dltq_pkg::ST_IDLE);
          ks.push_back(16'd0);
        end
      end
      n = st.size();
      for (int i = 0; i < n; i++)
        pending.push_back('{st[i], ks[i], count > 0 ? deltas[0] : 32'd0,
                            count == 0, i == n - 1});
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: got %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t mismatch: expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;

  timer_scoreboard board = new();
  int hold_cycles = 0;
  bit random_stall = 0;

  delta_list_timer_queue dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result('{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
                           m_axis_tdata[48], m_axis_tlast});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 0;
    end else if (random_stall) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= 1;
  end

  task automatic send_item(logic op, logic [15:0] k, logic [31:0] amt);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {amt, k};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item(op, k, amt);
  endtask

  task automatic pause(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_key();
    return $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 23));
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 5))
      0: return 32'($urandom);
      1: return 32'hffff_ffff;
      default: return 32'($urandom_range(1, 200));
    endcase
  endfunction

  initial begin
    board.clear();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_item(1, 16'hffff, 32'd5);
    send_item(0, 16'd1, 32'd0);
    send_item(0, 16'hffff, 32'hffff_ffff);
    send_item(0, 16'd0, 32'd1);
    send_item(0, 16'd2, 32'd1);
    send_item(0, 16'd3, 32'd10);
    send_item(0, 16'd2, 32'd7);
    send_item(0, 16'd2, 32'd0);
    send_item(0, 16'd2, 32'd0);
    send_item(1, 16'd0, 32'd0);
    send_item(1, 16'd0, 32'd1);
    drain();
    // fill beyond depth, all same time, then one big tick: burst plus full
    for (int i = 0; i < DEPTH + 2; i++) send_item(0, 16'(100 + i), 32'd3);
    send_item(0, 16'd100, 32'd9);
    send_item(1, 16'd0, 32'hffff_ffff);
    send_item(1, 16'd0, 32'd0);
    drain();
    random_stall = 1;
    for (int b = 0; b < 65; b++) begin
      if (b == 20) begin
        hold_cycles = 400;
        for (int i = 0; i < 12; i++) send_item(0, pick_key(), pick_time());
      end
      if (b == 40) drain();
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_item(0, pick_key(), pick_time());
          5, 6: send_item(0, pick_key(), 32'd0);
          default: send_item(1, 16'($urandom), $urandom_range(0, 3) == 0 ?
                             32'($urandom) : 32'($urandom_range(0, 150)));
        endcase
      end
      if ($urandom_range(0, 1)) pause($urandom_range(1, 20));
    end
    drain();
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
